// ===== rtl/smd_pkg.sv =====
// ----------------------------------------------------------------------------
// smd_pkg: shared definitions for the sRGB-aware mip downsampler
// Register indexes, half-float codes, control bundle and sRGB table builders.
// ----------------------------------------------------------------------------
package smd_pkg;

	localparam int MAX_WIDTH_DEF   = 4096;
	localparam int LINEAR_BITS_DEF = 16;
	localparam int HEIGHT_LIMIT    = 4096;

	// configuration register indexes
	localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [1:0] REG_ENCODING   = 2'd2;

	// texel encodings
	localparam logic [1:0] ENC_LINEAR8 = 2'd0;
	localparam logic [1:0] ENC_SRGB8   = 2'd1;
	localparam logic [1:0] ENC_HALF    = 2'd2;

	// half-float codes
	localparam logic [15:0] HALF_POS_INF = 16'h7C00;
	localparam logic [15:0] HALF_NEG_INF = 16'hFC00;
	localparam logic [15:0] HALF_QNAN    = 16'h7E00;
	localparam logic [15:0] HALF_NEG_ZRO = 16'h8000;

	// per-request control that travels along the averaging pipeline
	typedef struct packed {
		logic last;
		logic half;
		logic srgb;
		logic w1;
		logic h1;
	} smd_ctrl_t;

	function automatic longint unsigned pow5_q30(longint unsigned r);
		longint unsigned p;
		p = r;
		for (int i = 0; i < 4; i++) p = (p * r) >> 30;
		return p;
	endfunction

	// sRGB decode of k/510 in Q30
	function automatic longint unsigned decode_q30(int unsigned k);
		longint unsigned kk;
		longint unsigned xq;
		longint unsigned u;
		longint unsigned r;
		longint unsigned t;
		kk = longint'(k);
		r  = 0;
		if (kk <= 20) begin
			return (((64'd100 * kk) << 30) + 64'd329460) / 64'd658920;
		end
		xq = (((64'd1000 * kk + 64'd28050) << 30) + 64'd269025) / 64'd538050;
		if (xq > (64'd1 << 30)) xq = 64'd1 << 30;
		u = (xq * xq) >> 30;
		for (int b = 30; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t <= (64'd1 << 30) && pow5_q30(t) <= u) r = t;
		end
		return (u * r) >> 30;
	endfunction

	function automatic longint unsigned srgb_lin(int unsigned k, int lb);
		longint unsigned full;
		full = (64'd1 << lb) - 64'd1;
		return (decode_q30(k) * full + (64'd1 << 29)) >> 30;
	endfunction

endpackage

// ===== rtl/smd_row_mem.sv =====
// ----------------------------------------------------------------------------
// smd_row_mem: row store for the even source row
// One entry holds a horizontal texel pair; the read is synchronous.
// ----------------------------------------------------------------------------
module smd_row_mem #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [127:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [127:0]  rdata
);

	logic [127:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data while the pipeline stalls
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/smd_avg_pipe.sv =====
// ----------------------------------------------------------------------------
// smd_avg_pipe: 2x2 averaging pipeline
// Six register levels; 8-bit linear/sRGB and half paths run side by side.
// ----------------------------------------------------------------------------
module smd_avg_pipe #(
	parameter int LB = smd_pkg::LINEAR_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_vld,
	input  smd_pkg::smd_ctrl_t ctrl,
	input  logic [63:0]       cur,
	input  logic [63:0]       prev,
	input  logic [127:0]      rd,
	output logic              out_vld,
	output logic [63:0]       mip_texel,
	output logic              last_of_level
);

	// constant sRGB tables
	logic [LB-1:0] rom [256];
	logic [LB-1:0] thr [256];

	for (genvar g = 0; g < 256; g++) begin : g_tab
		assign rom[g] = LB'(smd_pkg::srgb_lin(2 * g, LB));
		if (g == 0) begin : g_zero
			assign thr[g] = '0;
		end else begin : g_thr
			assign thr[g] = LB'(smd_pkg::srgb_lin(2 * g - 1, LB));
		end
	end

	// ---------------- stage 1: texel select, ROM, magnitudes
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	smd_pkg::smd_ctrl_t ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5;
	logic [63:0]        cur_s1, prev_s1;

	logic [63:0]   t [4];
	logic [LB-1:0] avg_n [4];
	logic          col_n [4];
	logic [39:0]   mag_n [4][4];
	logic          sgn_n [4][4];
	logic          nan_n [4], pinf_n [4], ninf_n [4], anz_n [4];

	always_comb begin
		logic [LB+1:0] sum;
		logic [7:0]    code;
		logic [15:0]   hv;
		logic [4:0]    e;
		t[3] = cur_s1;
		t[2] = ctrl_s1.w1 ? cur_s1 : prev_s1;
		if (ctrl_s1.h1) begin
			t[0] = t[2];
			t[1] = t[3];
		end else begin
			t[1] = rd[127:64];
			t[0] = rd[63:0];
		end
		for (int c = 0; c < 4; c++) begin
			col_n[c] = ctrl_s1.srgb && (c < 3);
			sum = '0;
			for (int k = 0; k < 4; k++) begin
				code = t[k][8*c +: 8];
				sum  = sum + (col_n[c] ? (LB+2)'(rom[code]) : (LB+2)'(code));
			end
			avg_n[c] = LB'((sum + (LB+2)'(2)) >> 2);
			nan_n[c]  = 1'b0;
			pinf_n[c] = 1'b0;
			ninf_n[c] = 1'b0;
			anz_n[c]  = 1'b1;
			for (int k = 0; k < 4; k++) begin
				hv = t[k][16*c +: 16];
				e  = hv[14:10];
				sgn_n[c][k] = hv[15];
				if (hv != smd_pkg::HALF_NEG_ZRO) anz_n[c] = 1'b0;
				mag_n[c][k] = '0;
				if (e == 5'h1F) begin
					if (hv[9:0] != 10'd0) nan_n[c] = 1'b1;
					else if (hv[15]) ninf_n[c] = 1'b1;
					else pinf_n[c] = 1'b1;
				end else if (e == 5'd0) begin
					mag_n[c][k] = 40'(hv[9:0]);
				end else begin
					mag_n[c][k] = 40'({1'b1, hv[9:0]}) << (e - 5'd1);
				end
			end
		end
	end

	// ---------------- stage 2: half sums, upper sRGB search
	logic [LB-1:0] avg_s2 [4];
	logic          col_s2 [4];
	logic [39:0]   mag_s2 [4][4];
	logic          sgn_s2 [4][4];
	logic          nan_s2 [4], pinf_s2 [4], ninf_s2 [4], anz_s2 [4];

	logic [41:0]   pos_n [4], neg_n [4];
	logic [7:0]    chi_n [4];

	always_comb begin
		logic [7:0] tc;
		for (int c = 0; c < 4; c++) begin
			pos_n[c] = '0;
			neg_n[c] = '0;
			for (int k = 0; k < 4; k++) begin
				if (sgn_s2[c][k]) neg_n[c] = neg_n[c] + 42'(mag_s2[c][k]);
				else pos_n[c] = pos_n[c] + 42'(mag_s2[c][k]);
			end
			chi_n[c] = '0;
			for (int b = 7; b >= 4; b--) begin
				tc = chi_n[c] | (8'd1 << b);
				if (thr[tc] <= avg_s2[c]) chi_n[c] = tc;
			end
		end
	end

	// ---------------- stage 3: half specials and difference, lower search
	logic [LB-1:0] avg_s3 [4];
	logic          col_s3 [4];
	logic [7:0]    chi_s3 [4];
	logic [41:0]   pos_s3 [4], neg_s3 [4];
	logic          nan_s3 [4], pinf_s3 [4], ninf_s3 [4], anz_s3 [4];

	logic          spec_n [4];
	logic [15:0]   sval_n [4];
	logic [41:0]   a_n [4];
	logic          sign_n [4];
	logic [31:0]   tex8_n;

	always_comb begin
		logic [7:0] code;
		logic [7:0] tc;
		for (int c = 0; c < 4; c++) begin
			spec_n[c] = 1'b1;
			sval_n[c] = 16'd0;
			sign_n[c] = 1'b0;
			a_n[c]    = pos_s3[c] - neg_s3[c];
			if (nan_s3[c] || (pinf_s3[c] && ninf_s3[c])) begin
				sval_n[c] = smd_pkg::HALF_QNAN;
			end else if (pinf_s3[c]) begin
				sval_n[c] = smd_pkg::HALF_POS_INF;
			end else if (ninf_s3[c]) begin
				sval_n[c] = smd_pkg::HALF_NEG_INF;
			end else if (pos_s3[c] == neg_s3[c]) begin
				sval_n[c] = anz_s3[c] ? smd_pkg::HALF_NEG_ZRO : 16'd0;
			end else begin
				spec_n[c] = 1'b0;
				if (neg_s3[c] > pos_s3[c]) begin
					sign_n[c] = 1'b1;
					a_n[c]    = neg_s3[c] - pos_s3[c];
				end
			end
			code = chi_s3[c];
			for (int b = 3; b >= 0; b--) begin
				tc = code | (8'd1 << b);
				if (thr[tc] <= avg_s3[c]) code = tc;
			end
			tex8_n[8*c +: 8] = col_s3[c] ? code : avg_s3[c][7:0];
		end
	end

	// ---------------- stage 4: leading-one detect
	logic        spec_s4 [4], sign_s4 [4];
	logic [15:0] sval_s4 [4];
	logic [41:0] a_s4 [4];
	logic [31:0] tex8_s4;

	logic [5:0]  p_n [4];
	logic        und_n [4];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			und_n[c] = (a_s4[c][41:12] == 30'd0);
			p_n[c]   = 6'd12;
			for (int i = 12; i < 42; i++) begin
				if (a_s4[c][i]) p_n[c] = 6'(i);
			end
		end
	end

	// ---------------- stage 5: pack
	logic        spec_s5 [4], sign_s5 [4], und_s5 [4];
	logic [15:0] sval_s5 [4];
	logic [41:0] a_s5 [4];
	logic [5:0]  p_s5 [4];
	logic [31:0] tex8_s5;

	logic [63:0] res_n;

	always_comb begin
		logic [41:0] sh;
		for (int c = 0; c < 4; c++) begin
			sh = a_s5[c] >> (p_s5[c] - 6'd10);
			if (spec_s5[c]) begin
				res_n[16*c +: 16] = sval_s5[c];
			end else if (und_s5[c]) begin
				res_n[16*c +: 16] = {sign_s5[c], 15'd0};
			end else begin
				res_n[16*c +: 16] = {sign_s5[c], 5'(p_s5[c] - 6'd11), sh[9:0]};
			end
		end
		if (!ctrl_s5.half) res_n = {32'd0, tex8_s5};
	end

	// ---------------- valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			out_vld <= 1'b0;
		end else if (adv) begin
			v_s1    <= in_vld;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			out_vld <= v_s5;
		end
	end

	// ---------------- payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			cur_s1  <= cur;
			prev_s1 <= prev;
			ctrl_s1 <= ctrl;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= ctrl_s4;
			for (int c = 0; c < 4; c++) begin
				avg_s2[c]  <= avg_n[c];
				col_s2[c]  <= col_n[c];
				nan_s2[c]  <= nan_n[c];
				pinf_s2[c] <= pinf_n[c];
				ninf_s2[c] <= ninf_n[c];
				anz_s2[c]  <= anz_n[c];
				for (int k = 0; k < 4; k++) begin
					mag_s2[c][k] <= mag_n[c][k];
					sgn_s2[c][k] <= sgn_n[c][k];
				end
				avg_s3[c]  <= avg_s2[c];
				col_s3[c]  <= col_s2[c];
				chi_s3[c]  <= chi_n[c];
				pos_s3[c]  <= pos_n[c];
				neg_s3[c]  <= neg_n[c];
				nan_s3[c]  <= nan_s2[c];
				pinf_s3[c] <= pinf_s2[c];
				ninf_s3[c] <= ninf_s2[c];
				anz_s3[c]  <= anz_s2[c];
				spec_s4[c] <= spec_n[c];
				sval_s4[c] <= sval_n[c];
				a_s4[c]    <= a_n[c];
				sign_s4[c] <= sign_n[c];
				spec_s5[c] <= spec_s4[c];
				sval_s5[c] <= sval_s4[c];
				a_s5[c]    <= a_s4[c];
				sign_s5[c] <= sign_s4[c];
				und_s5[c]  <= und_n[c];
				p_s5[c]    <= p_n[c];
			end
			tex8_s4       <= tex8_n;
			tex8_s5       <= tex8_s4;
			mip_texel     <= res_n;
			last_of_level <= ctrl_s5.last;
		end
	end

endmodule

// ===== rtl/srgb_aware_mip_downsampler_top.sv =====
// ----------------------------------------------------------------------------
// srgb_aware_mip_downsampler_top: one mip level by 2x2 box filtering
// Raster-order source texels in, raster-order destination texels out.
// ----------------------------------------------------------------------------
// Usage:
//   Program src_width, src_height and texel_encoding through the cfg write
//   port while the block is idle; writes to these restart the level at (0,0).
//   Source texels arrive on source_valid/source_ready, one request per
//   cycle while no result is stalled. On the odd source row, every odd column
//   (or every texel when the size is 1) produces one destination request on
//   mip_valid/mip_ready; last_of_level flags the final texel of the level.
//   After the last source texel the position wraps and a new level starts.
//   From source acceptance to mip_valid a result passes the registers of the
//   averaging pipeline (ROM decode, sums, sRGB search, leading-one, pack).
//   Throughput: one source texel per cycle while no result is stalled; the
//   row store is read and written once per cycle at most.
//   Stall: when mip_valid is high and mip_ready low the whole pipeline and
//   the row store read port hold, and source_ready drops in the same cycle.
//   Reset: arst_n clears positions, the previous texel, all valid bits and
//   the registers to 1x1 sRGB. The row store is not cleared; it is always
//   written on the even row before the odd row reads it.
// ----------------------------------------------------------------------------
module srgb_aware_mip_downsampler_top #(
	parameter int MAX_WIDTH   = smd_pkg::MAX_WIDTH_DEF,
	parameter int LINEAR_BITS = smd_pkg::LINEAR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        source_valid,
	output logic        source_ready,
	input  logic [63:0] source_texel,
	output logic        mip_valid,
	input  logic        mip_ready,
	output logic [63:0] mip_texel,
	output logic        last_of_level,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_wdata
);

	// one row store entry per horizontal texel pair
	localparam int DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int XW    = AW + 1;
	localparam int WW    = XW + 1;

	logic [WW-1:0] w_q;
	logic [12:0]   h_q;
	logic [1:0]    enc_q;
	logic [XW-1:0] x_q;
	logic [11:0]   y_q;
	logic [63:0]   prev_q;

	logic          adv, accept;
	logic          w1, h1, col_second, row_second, last_col, last_row;
	logic [WW-1:0] w_even;
	logic [12:0]   h_even;
	logic          mem_we;
	logic [127:0]  mem_wdata, mem_rdata;
	smd_pkg::smd_ctrl_t ctrl;

	// advance whenever the output register is free or being drained
	assign adv          = !mip_valid || mip_ready;
	assign source_ready = adv;
	assign accept       = source_valid && adv;

	assign w1     = (w_q == WW'(1));
	assign h1     = (h_q == 13'd1);
	assign w_even = {w_q[WW-1:1], 1'b0};
	assign h_even = {h_q[12:1], 1'b0};

	// second column / row of a 2x2 block; size 1 reuses its single line
	assign col_second = w1 ? (x_q == '0) : (x_q[0] && ({1'b0, x_q} < w_even));
	assign row_second = h1 ? (y_q == '0) : (y_q[0] && ({1'b0, y_q} < h_even));
	assign last_col   = w1 || ({1'b0, x_q} == w_even - WW'(1));
	assign last_row   = h1 || ({1'b0, y_q} == h_even - 13'd1);

	always_comb begin
		ctrl.last = last_col && last_row;
		ctrl.half = (enc_q == smd_pkg::ENC_HALF);
		ctrl.srgb = (enc_q == smd_pkg::ENC_SRGB8);
		ctrl.w1   = w1;
		ctrl.h1   = h1;
	end

	// write the even row pairwise: odd column stores {this, previous}, width 1 stores {this, this}
	assign mem_we    = accept && !h1 && !y_q[0] && (x_q[0] || w1);
	assign mem_wdata = w1 ? {source_texel, source_texel} : {source_texel, prev_q};

	smd_row_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (x_q[XW-1:1]),
		.wdata (mem_wdata),
		.re    (adv),
		.raddr (x_q[XW-1:1]),
		.rdata (mem_rdata)
	);

	smd_avg_pipe #(
		.LB (LINEAR_BITS)
	) u_pipe (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_vld        (accept && col_second && row_second),
		.ctrl          (ctrl),
		.cur           (source_texel),
		.prev          (prev_q),
		.rd            (mem_rdata),
		.out_vld       (mip_valid),
		.mip_texel     (mip_texel),
		.last_of_level (last_of_level)
	);

	// configuration and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q    <= WW'(1);
			h_q    <= 13'd1;
			enc_q  <= smd_pkg::ENC_SRGB8;
			x_q    <= '0;
			y_q    <= '0;
			prev_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				smd_pkg::REG_SRC_WIDTH: begin
					if (cfg_wdata == 13'd0) w_q <= WW'(1);
					else if (32'(cfg_wdata) > 32'(MAX_WIDTH)) w_q <= WW'(MAX_WIDTH);
					else w_q <= WW'(cfg_wdata);
				end
				smd_pkg::REG_SRC_HEIGHT: begin
					if (cfg_wdata == 13'd0) h_q <= 13'd1;
					else if (32'(cfg_wdata) > 32'(smd_pkg::HEIGHT_LIMIT)) begin
						h_q <= 13'(smd_pkg::HEIGHT_LIMIT);
					end else h_q <= cfg_wdata;
				end
				smd_pkg::REG_ENCODING: begin
					enc_q <= cfg_wdata[1:0];
				end
				default: begin
				end
			endcase
			// restart the level on any listed register
			if (cfg_index != 2'd3) begin
				x_q <= '0;
				y_q <= '0;
			end
		end else if (accept) begin
			prev_q <= source_texel;
			if (({1'b0, x_q} + WW'(1)) >= w_q) begin
				x_q <= '0;
				if ((13'({1'b0, y_q}) + 13'd1) >= h_q) y_q <= '0;
				else y_q <= y_q + 12'd1;
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
	end

endmodule

// ===== rtl/smd_checker.sv =====
// ----------------------------------------------------------------------------
// smd_checker: port-level checks for the mip downsampler
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
module smd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        source_ready,
	input logic        mip_valid,
	input logic        mip_ready,
	input logic [63:0] mip_texel,
	input logic        last_of_level
);

	// a stalled result blocks new source requests
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		mip_valid && !mip_ready |-> !source_ready)
		else $error("source accepted while result stalled");

	// a free output side always takes source requests
	a_free_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!mip_valid |-> source_ready)
		else $error("source blocked with empty output");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mip_valid && !mip_ready |=> mip_valid && $stable(mip_texel)
		&& $stable(last_of_level))
		else $error("stalled result changed");

endmodule

bind srgb_aware_mip_downsampler_top smd_checker u_smd_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for srgb_aware_mip_downsampler_top
// Streams source levels of many sizes and encodings through the block, works
// out every destination texel with its own 2x2 box-filter predictor and
// checks each mip request in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;

	localparam int MAXW = smd_pkg::MAX_WIDTH_DEF;

	logic        clk;
	logic        arst_n;
	logic        source_valid;
	logic        source_ready;
	logic [63:0] source_texel;
	logic        mip_valid;
	logic        mip_ready;
	logic [63:0] mip_texel;
	logic        last_of_level;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_wdata;

	srgb_aware_mip_downsampler_top dut (
		.clk(clk), .arst_n(arst_n),
		.source_valid(source_valid), .source_ready(source_ready),
		.source_texel(source_texel),
		.mip_valid(mip_valid), .mip_ready(mip_ready),
		.mip_texel(mip_texel), .last_of_level(last_of_level),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	typedef struct {
		logic [63:0] texel;
		logic        last;
	} mip_result_t;

	// predictor state: its own copy of the block's registers and position
	logic [63:0] line_buf [MAXW];
	logic [63:0] prev_texel;
	int unsigned col_pos, row_pos;
	int unsigned width_q, height_q;
	logic [1:0]  enc_q;
	int unsigned to_lin [256];
	int unsigned lin_thr [256];

	mip_result_t pending_mips[$];
	int  mismatches;
	int  texels_sent;
	int  mips_checked;
	bit  idle_on;
	bit  hold_req = 1'b0;
	int  hold_cnt = 0;

	// ------------------------------------------------------------------
	// sRGB tables: decode of k/510 in Q30, rounded to 16-bit linear
	// ------------------------------------------------------------------
	function automatic longint unsigned fifth_power(longint unsigned r);
		longint unsigned p;
		p = r;
		for (int i = 0; i < 4; i++) p = (p * r) >> 30;
		return p;
	endfunction

	function automatic longint unsigned srgb_decode_q30(int unsigned k);
		longint unsigned x, sq, root, trial, one;
		one = 64'd1 << 30;
		root = 0;
		if (k <= 20) return ((64'd100 * k << 30) + 64'd329460) / 64'd658920;
		x = (((64'd1000 * k + 64'd28050) << 30) + 64'd269025) / 64'd538050;
		if (x > one) x = one;
		sq = (x * x) >> 30;
		for (int b = 30; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial <= one && fifth_power(trial) <= sq) root = trial;
		end
		return (sq * root) >> 30;
	endfunction

	function automatic int unsigned q30_to_lin16(longint unsigned q);
		return int'((q * 64'd65535 + (64'd1 << 29)) >> 30);
	endfunction

	function automatic logic [7:0] lin_to_srgb(int unsigned v);
		int unsigned code;
		code = 0;
		for (int c = 1; c < 256; c++) if (v >= lin_thr[c]) code++;
		return code[7:0];
	endfunction

	// ------------------------------------------------------------------
	// per-channel averages
	// ------------------------------------------------------------------
	function automatic logic [63:0] avg_8bit(logic [63:0] t [4], bit srgb);
		logic [63:0] r;
		int unsigned s, v;
		bit colour;
		r = '0;
		for (int c = 0; c < 4; c++) begin
			colour = srgb && c < 3;
			s = 0;
			for (int k = 0; k < 4; k++)
				s += colour ? to_lin[t[k][8*c +: 8]] : t[k][8*c +: 8];
			v = (s + 2) >> 2;
			if (colour) v = lin_to_srgb(v);
			r[8*c +: 8] = v[7:0];
		end
		return r;
	endfunction

	function automatic logic [15:0] avg_half(logic [63:0] t [4], int c);
		longint unsigned pos, neg, a, mag;
		bit nan, pinf, ninf, all_nz;
		logic [15:0] h, sgn;
		int unsigned e, m, p;
		pos = 0; neg = 0; nan = 0; pinf = 0; ninf = 0; all_nz = 1;
		for (int k = 0; k < 4; k++) begin
			h = t[k][16*c +: 16];
			e = h[14:10];
			m = h[9:0];
			if (h != smd_pkg::HALF_NEG_ZRO) all_nz = 0;
			if (e == 31) begin
				if (m != 0) nan = 1;
				else if (h[15]) ninf = 1;
				else pinf = 1;
			end else begin
				mag = (e == 0) ? m : (longint'(1024 + m) << (e - 1));
				if (h[15]) neg += mag; else pos += mag;
			end
		end
		if (nan || (pinf && ninf)) return smd_pkg::HALF_QNAN;
		if (pinf) return smd_pkg::HALF_POS_INF;
		if (ninf) return smd_pkg::HALF_NEG_INF;
		if (pos == neg) return all_nz ? smd_pkg::HALF_NEG_ZRO : 16'h0000;
		if (pos > neg) begin
			a = pos - neg; sgn = 16'h0000;
		end else begin
			a = neg - pos; sgn = 16'h8000;
		end
		// a is the average in units of 2^-26: flush below 2^-14
		if (a < (64'd1 << 12)) return sgn;
		p = 12;
		while (p < 63 && (a >> (p + 1)) != 0) p++;
		if (p >= 42) return sgn | smd_pkg::HALF_POS_INF;
		return sgn | 16'((p - 11) << 10) | 16'((a >> (p - 10)) & 64'h3FF);
	endfunction

	// ------------------------------------------------------------------
	// predictor: register writes and one accepted source texel
	// ------------------------------------------------------------------
	function automatic void apply_cfg(logic [1:0] idx, logic [12:0] v);
		int unsigned n;
		n = v;
		case (idx)
			smd_pkg::REG_SRC_WIDTH: width_q = (n == 0) ? 1 : (n > MAXW ? MAXW : n);
			smd_pkg::REG_SRC_HEIGHT:
				height_q = (n == 0) ? 1 :
					(n > smd_pkg::HEIGHT_LIMIT ? smd_pkg::HEIGHT_LIMIT : n);
			smd_pkg::REG_ENCODING: enc_q = v[1:0];
			default: return;
		endcase
		col_pos = 0;
		row_pos = 0;
	endfunction

	function automatic void downsample_step(logic [63:0] cur);
		int unsigned dw, dh, dx, dy;
		bit w1, h1, col2, row2;
		logic [63:0] t [4];
		mip_result_t r;
		dw = (width_q / 2 == 0) ? 1 : width_q / 2;
		dh = (height_q / 2 == 0) ? 1 : height_q / 2;
		w1 = (width_q == 1);
		h1 = (height_q == 1);
		col2 = w1 ? (col_pos == 0) : (col_pos[0] && col_pos < 2 * dw);
		row2 = h1 ? (row_pos == 0) : (row_pos[0] && row_pos < 2 * dh);
		if (col2 && row2 && col_pos < MAXW) begin
			dx = w1 ? 0 : col_pos >> 1;
			dy = h1 ? 0 : row_pos >> 1;
			t[3] = cur;
			t[2] = w1 ? cur : prev_texel;
			if (h1) begin
				t[0] = t[2];
				t[1] = t[3];
			end else begin
				t[1] = line_buf[col_pos];
				t[0] = w1 ? line_buf[col_pos] : line_buf[col_pos - 1];
			end
			if (enc_q == smd_pkg::ENC_HALF) begin
				for (int c = 0; c < 4; c++) r.texel[16*c +: 16] = avg_half(t, c);
			end else begin
				r.texel = avg_8bit(t, enc_q == smd_pkg::ENC_SRGB8);
			end
			r.last = (dx == dw - 1 && dy == dh - 1);
			pending_mips = {pending_mips, r};
		end
		if (!h1 && !row_pos[0] && col_pos < MAXW) line_buf[col_pos] = cur;
		prev_texel = cur;
		col_pos++;
		if (col_pos >= width_q) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= height_q) row_pos = 0;
		end
	endfunction

	// ------------------------------------------------------------------
	// clock, reset, limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("srgb_aware_mip_downsampler_top test failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// receiver: random ready, with a long counted hold-off on request
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req && hold_cnt == 0) begin
			hold_cnt <= 300;
			mip_ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			mip_ready <= (hold_cnt == 1);
		end else begin
			mip_ready <= idle_on ? ($urandom_range(99) >= 16) : 1'b1;
		end
	end

	// check each accepted mip request against the oldest prediction
	always @(posedge clk) begin
		mip_result_t e;
		if (arst_n && mip_valid && mip_ready) begin
			if (pending_mips.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected mip request %h last=%b", $realtime,
						mip_texel, last_of_level);
			end else begin
				e = pending_mips.pop_front();
				mips_checked++;
				if (mip_texel !== e.texel || last_of_level !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mip mismatch exp %h/%b got %h/%b", $realtime,
							e.texel, e.last, mip_texel, last_of_level);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// driver tasks
	// ------------------------------------------------------------------
	// offer one source request; valid stays high into the next request
	task automatic send_texel(logic [63:0] t);
		if (idle_on && $urandom_range(99) < 16) begin
			source_valid <= 1'b0;
			@(posedge clk);
		end
		source_valid <= 1'b1;
		source_texel <= t;
		do @(posedge clk); while (!(source_valid && source_ready));
		downsample_step(t);
		texels_sent++;
	endtask

	// drop valid and let the pipeline drain before touching registers
	task automatic drain();
		source_valid <= 1'b0;
		@(posedge clk);
		while (pending_mips.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [12:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		apply_cfg(idx, v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_level(logic [12:0] w, logic [12:0] h, logic [1:0] enc);
		write_reg(smd_pkg::REG_SRC_WIDTH, w);
		write_reg(smd_pkg::REG_SRC_HEIGHT, h);
		write_reg(smd_pkg::REG_ENCODING, enc);
	endtask

	function automatic logic [15:0] rand_half();
		case ($urandom_range(9))
			0: return smd_pkg::HALF_POS_INF | 16'($urandom_range(1) << 15);
			1: return 16'h7C00 | 16'($urandom_range(1, 1023)) | 16'($urandom_range(1) << 15);
			2: return 16'($urandom_range(1) << 15);
			3: return 16'($urandom_range(1023)) | 16'($urandom_range(1) << 15);
			4: return 16'h7800 | 16'($urandom_range(1023)) | 16'($urandom_range(1) << 15);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] rand_texel(logic [1:0] enc);
		if (enc == smd_pkg::ENC_HALF)
			return {rand_half(), rand_half(), rand_half(), rand_half()};
		return {$urandom, $urandom};
	endfunction

	task automatic send_random(int n, logic [1:0] enc);
		for (int i = 0; i < n; i++) send_texel(rand_texel(enc));
	endtask

	// stream whole levels
	task automatic run_levels(int unsigned w, int unsigned h, logic [1:0] enc, int n);
		int unsigned wc, hc;
		wc = (w == 0) ? 1 : (w > MAXW ? MAXW : w);
		hc = (h == 0) ? 1 : (h > smd_pkg::HEIGHT_LIMIT ? smd_pkg::HEIGHT_LIMIT : h);
		for (int i = 0; i < n * wc * hc; i++) send_texel(rand_texel(enc));
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		logic [63:0] pat [8];
		pat = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_FF00_FF00,
			64'h0000_0000_00FF_00FF, 64'h0000_0000_0101_0101, 64'h0000_0000_FEFE_FEFE,
			64'h8000_8000_8000_8000, 64'h7C00_FC00_7E00_0001};
		// reset default is a 1x1 sRGB level: every texel is its own result
		for (int i = 0; i < 6; i++) send_texel(pat[i]);
		drain();
		set_level(2, 2, smd_pkg::ENC_LINEAR8);
		for (int i = 0; i < 4; i++) send_texel(pat[i]);
		drain();
		// half: all negative zero, mixed zeros, opposite infinities, NaN
		set_level(2, 2, smd_pkg::ENC_HALF);
		for (int i = 0; i < 4; i++) send_texel(pat[6]);
		send_texel(64'h8000_8000_8000_8000); send_texel(64'h0000_8000_0000_8000);
		send_texel(64'h7C00_7C00_7C00_7C00); send_texel(64'hFC00_FC00_7C01_7BFF);
		send_texel(64'h7BFF_7BFF_0001_0400); send_texel(64'h7BFF_7BFF_0001_8400);
		send_texel(64'h7BFF_FBFF_0003_0000); send_texel(pat[7]);
		drain();
		// unused encoding behaves as linear 8-bit
		set_level(1, 1, 2'd3);
		send_texel(pat[3]);
		drain();
	endtask

	task automatic test_random_levels();
		int unsigned w, h;
		logic [1:0] enc;
		for (int ph = 0; ph < 20; ph++) begin
			w = $urandom_range(1, 9);
			h = $urandom_range(1, 7);
			enc = $urandom_range(3);
			// one long stretch with no idling on either side
			idle_on = !(ph >= 8 && ph < 14);
			set_level(w, h, enc);
			run_levels(w, h, enc, $urandom_range(1, 2));
			// partial level, then a write restarts it
			for (int i = $urandom_range(w * h); i > 0; i--) send_texel(rand_texel(enc));
			drain();
		end
		idle_on = 1;
	endtask

	// clamped sizes: the large ones run as a partial level that the next write restarts
	task automatic test_extreme_sizes();
		set_level(13'd4096, 1, smd_pkg::ENC_SRGB8);
		send_random(48, smd_pkg::ENC_SRGB8);
		drain();
		set_level(13'd8191, 0, smd_pkg::ENC_HALF);
		send_random(48, smd_pkg::ENC_HALF);
		drain();
		set_level(1, 13'd5000, smd_pkg::ENC_LINEAR8);
		send_random(48, smd_pkg::ENC_LINEAR8);
		drain();
		set_level(0, 3, smd_pkg::ENC_LINEAR8);
		run_levels(0, 3, smd_pkg::ENC_LINEAR8, 2);
		drain();
	endtask

	task automatic test_backpressure();
		set_level(2, 1, smd_pkg::ENC_SRGB8);
		hold_req <= 1'b1;
		@(posedge clk);
		hold_req <= 1'b0;
		run_levels(2, 1, smd_pkg::ENC_SRGB8, 60);
		drain();
	endtask

	task automatic test_spare_index();
		// an index with no register must not restart the level
		set_level(4, 4, smd_pkg::ENC_LINEAR8);
		run_levels(4, 2, smd_pkg::ENC_LINEAR8, 1);
		drain();
		write_reg(2'd3, 13'h1FFF);
		run_levels(4, 2, smd_pkg::ENC_LINEAR8, 1);
		drain();
	endtask

	initial begin
		for (int i = 0; i < 256; i++) to_lin[i] = q30_to_lin16(srgb_decode_q30(2 * i));
		lin_thr[0] = 0;
		for (int i = 1; i < 256; i++) lin_thr[i] = q30_to_lin16(srgb_decode_q30(2 * i - 1));
		for (int i = 0; i < MAXW; i++) line_buf[i] = '0;
		prev_texel = '0; col_pos = 0; row_pos = 0;
		width_q = 1; height_q = 1; enc_q = smd_pkg::ENC_SRGB8;
		mismatches = 0; texels_sent = 0; mips_checked = 0;
		idle_on = 1;
		arst_n <= 1'b0;
		source_valid <= 1'b0;
		source_texel <= '0;
		mip_ready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= smd_pkg::REG_SRC_WIDTH;
		cfg_wdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_levels();
		test_extreme_sizes();
		test_backpressure();
		test_spare_index();

		drain();
		$display("Covered %0d source texels and %0d mip texels over linear, sRGB and half",
			texels_sent, mips_checked);
		$display("levels from 1x1 up to clamped 4096 wide, with idling, a long stall");
		if (mismatches == 0 && pending_mips.size() == 0) begin
			$display("srgb_aware_mip_downsampler_top test passed");
		end else begin
			$display("srgb_aware_mip_downsampler_top test failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/smd_pkg.sv
rtl/smd_row_mem.sv
rtl/smd_avg_pipe.sv
rtl/srgb_aware_mip_downsampler_top.sv
rtl/smd_checker.sv
tb/sv/tb.sv
